@@ hw/rtl/element_compliance_sensitivity_assert.svh @@
// assertion macros shared by the element compliance rtl
// the checking forms expect clk and rst_n in the enclosing module
`ifndef ELEMENT_COMPLIANCE_SENSITIVITY_ASSERT_SVH
`define ELEMENT_COMPLIANCE_SENSITIVITY_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ECS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecs assertion failed");
// next-cycle implication
`define ECS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecs assertion failed");
`else
`define ECS_ASSERT_IMP(lbl, ante, cons)
`define ECS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/ecs_pkg.sv @@
// shared types, widths, stiffness layout and sequencer step codes
// for the element compliance block; no dependencies
package ecs_pkg;

  localparam int NUM_LANES = 8;
  localparam int NUM_K     = 8;
  localparam int DISP_W    = 32;
  localparam int K_W       = 32;
  localparam int DENS_W    = 17;
  localparam int CFG_IDX_W = 8;
  localparam int COL_W     = 3;

  localparam int PROD_W    = DISP_W + K_W;      // k * u
  localparam int ROW_W     = PROD_W + 3;        // sum of eight products
  localparam int LO_W      = 34;                // low slice of the row sum
  localparam int PLO_W     = DISP_W + LO_W + 1;
  localparam int PHI_W     = DISP_W + ROW_W - LO_W;
  localparam int LANE_W    = 98;                // u[r] * row sum
  localparam int SUM_W     = LANE_W + 3;        // after the 8-way tree

  localparam int ENERGY_W  = 48;
  localparam int SENS_W    = 49;
  localparam int TOTAL_W   = 63;
  localparam int E3_W      = ENERGY_W + 2;
  localparam int E3_HALF   = E3_W / 2;
  localparam int D2_W      = 2 * DENS_W;
  localparam int PP_W      = E3_HALF + D2_W;
  localparam int FULL_W    = PP_W + E3_HALF + 1;
  localparam int FRAC_SH   = 30;
  localparam int SENS_SH   = 32;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [SENS_W-1:0]   SENS_MAG_MAX = {1'b1, {(SENS_W-1){1'b0}}};
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX = '1;

  // sequencer steps
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_MAC_LAST = 5'd7;
  localparam logic [STEP_W-1:0] STEP_ADD_LAST = 5'd8;
  localparam logic [STEP_W-1:0] STEP_FIN_MUL  = 5'd9;
  localparam logic [STEP_W-1:0] STEP_FIN_ADD  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_TREE1    = 5'd11;
  localparam logic [STEP_W-1:0] STEP_TREE2    = 5'd12;
  localparam logic [STEP_W-1:0] STEP_TREE3    = 5'd13;
  localparam logic [STEP_W-1:0] STEP_SAT      = 5'd14;
  localparam logic [STEP_W-1:0] STEP_E3       = 5'd15;
  localparam logic [STEP_W-1:0] STEP_MUL      = 5'd16;
  localparam logic [STEP_W-1:0] STEP_COMB     = 5'd17;
  localparam logic [STEP_W-1:0] STEP_LAST     = 5'd18;

  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic signed [K_W-1:0]    stiff_t;
  typedef logic signed [LANE_W-1:0] lane_sum_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic add;
    logic fin_mul;
    logic fin_add;
  } lane_ctrl_t;

  typedef struct packed {
    logic tree1;
    logic tree2;
    logic tree3;
    logic sat;
    logic e3;
    logic mul;
    logic comb;
  } merge_ctrl_t;

  // which stiffness word sits at row, column of the symmetric matrix
  localparam logic [COL_W-1:0] KIDX [NUM_LANES][NUM_LANES] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2},
    '{3'd2, 3'd7, 3'd0, 3'd5, 3'd6, 3'd3, 3'd4, 3'd1},
    '{3'd3, 3'd6, 3'd5, 3'd0, 3'd7, 3'd2, 3'd1, 3'd4},
    '{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6},
    '{3'd6, 3'd3, 3'd4, 3'd1, 3'd2, 3'd7, 3'd0, 3'd5},
    '{3'd7, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd0}
  };

  // plane stress, nu = 0.3, unit modulus, q2.30
  localparam stiff_t KRESET [NUM_K] = '{
    32'sd530971232, 32'sd191739611, -32'sd324482419, -32'sd14749201,
    -32'sd265485616, -32'sd191739611, 32'sd58996804, 32'sd14749201
  };

endpackage

@@ hw/rtl/element_compliance_sensitivity.sv @@
// top level of the element compliance and sensitivity block
// uses ecs_pkg, ecs_lane, ecs_merge and the assertion macro header
//
// Takes one bilinear quad element per input word (eight q16.16 nodal
// displacements and a q1.16 density) and returns one word holding the
// element energy u^T K u (q16.32, clamped to zero when negative and
// saturated at the top), the sensitivity -3*energy*density^2 and a running
// total of energies that restarts when the tuser flag is set. After the
// accept, eight lanes each run the multiply-accumulate of one stiffness
// row and the product with their own displacement, then the merge stage
// runs the adder tree, energy clamping and the sensitivity product, and
// the output register is loaded. A new element is taken only once the
// last is loaded there, so one is accepted while a finished result still
// waits on out_tready; a result left waiting holds the block at its final
// step. Stiffness words must be written through the cfg port only while
// no element is in flight; the block does not enforce this. cfg_ready is
// always high and writes to an index above 7 are dropped.
`include "element_compliance_sensitivity_assert.svh"

module element_compliance_sensitivity (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // disp_0 .. disp_7 (32 bits each), density (17), zero fill
  input  logic [279:0]  in_tdata,
  // restart_sum
  input  logic [0:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // energy (48), sensitivity (49), total_cost (63)
  output logic [159:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [ecs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecs_pkg::K_W-1:0]       cfg_data
);

  localparam int DENS_LSB = ecs_pkg::NUM_LANES * ecs_pkg::DISP_W;

  ecs_pkg::stiff_t                  stiff_r [ecs_pkg::NUM_K];
  ecs_pkg::disp_t                   disp_r  [ecs_pkg::NUM_LANES];
  logic [ecs_pkg::DENS_W-1:0]       density_r;
  logic                             restart_r;
  logic                             busy_r;
  logic [ecs_pkg::STEP_W-1:0]       step_r;
  logic                             out_valid_r;
  logic [ecs_pkg::ENERGY_W-1:0]     out_energy_r;
  logic [ecs_pkg::SENS_W-1:0]       out_sens_r;
  logic [ecs_pkg::TOTAL_W-1:0]      total_r;

  logic                             in_acc;
  logic                             out_load;
  ecs_pkg::lane_ctrl_t              lane_ctrl;
  ecs_pkg::merge_ctrl_t             merge_ctrl;
  ecs_pkg::lane_sum_t               lane_sum [ecs_pkg::NUM_LANES];
  ecs_pkg::disp_t                   u_col;
  logic [ecs_pkg::COL_W-1:0]        col;
  logic [ecs_pkg::ENERGY_W-1:0]     energy;
  logic [ecs_pkg::SENS_W-1:0]       sens_mag;
  logic [ecs_pkg::TOTAL_W-1:0]      total_base;
  logic [ecs_pkg::TOTAL_W:0]        total_sum;
  logic [ecs_pkg::TOTAL_W-1:0]      total_nxt;

  assign in_tready = !busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = busy_r && (step_r == ecs_pkg::STEP_LAST) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ecs_pkg::NUM_K; i++) begin
        stiff_r[i] <= ecs_pkg::KRESET[i];
      end
    end else if (cfg_valid && (cfg_index < ecs_pkg::CFG_IDX_W'(ecs_pkg::NUM_K))) begin
      stiff_r[cfg_index[ecs_pkg::COL_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < ecs_pkg::NUM_LANES; i++) begin
        disp_r[i] <= in_tdata[i*ecs_pkg::DISP_W +: ecs_pkg::DISP_W];
      end
      density_r <= in_tdata[DENS_LSB +: ecs_pkg::DENS_W];
      restart_r <= in_tuser[0];
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (out_load) begin
      busy_r <= 1'b0;
    end else if (busy_r && (step_r != ecs_pkg::STEP_LAST)) begin
      step_r <= step_r + 1'b1;
    end
  end

  assign col   = step_r[ecs_pkg::COL_W-1:0];
  assign u_col = disp_r[col];

  always_comb begin
    lane_ctrl.clr     = in_acc;
    lane_ctrl.mul     = busy_r && (step_r <= ecs_pkg::STEP_MAC_LAST);
    lane_ctrl.add     = busy_r && (step_r != '0) && (step_r <= ecs_pkg::STEP_ADD_LAST);
    lane_ctrl.fin_mul = busy_r && (step_r == ecs_pkg::STEP_FIN_MUL);
    lane_ctrl.fin_add = busy_r && (step_r == ecs_pkg::STEP_FIN_ADD);
    merge_ctrl.tree1  = busy_r && (step_r == ecs_pkg::STEP_TREE1);
    merge_ctrl.tree2  = busy_r && (step_r == ecs_pkg::STEP_TREE2);
    merge_ctrl.tree3  = busy_r && (step_r == ecs_pkg::STEP_TREE3);
    merge_ctrl.sat    = busy_r && (step_r == ecs_pkg::STEP_SAT);
    merge_ctrl.e3     = busy_r && (step_r == ecs_pkg::STEP_E3);
    merge_ctrl.mul    = busy_r && (step_r == ecs_pkg::STEP_MUL);
    merge_ctrl.comb   = busy_r && (step_r == ecs_pkg::STEP_COMB);
  end

  for (genvar g = 0; g < ecs_pkg::NUM_LANES; g++) begin : g_lane
    ecs_lane #(
      .LANE (g)
    ) u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .col      (col),
      .stiff    (stiff_r),
      .u_col    (u_col),
      .u_own    (disp_r[g]),
      .lane_sum (lane_sum[g])
    );
  end

  ecs_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .lane_sum (lane_sum),
    .density  (density_r),
    .energy   (energy),
    .sens_mag (sens_mag)
  );

  // running total, saturating
  assign total_base = restart_r ? '0 : total_r;
  assign total_sum  = (ecs_pkg::TOTAL_W+1)'(total_base) + (ecs_pkg::TOTAL_W+1)'(energy);
  assign total_nxt  = total_sum[ecs_pkg::TOTAL_W] ? ecs_pkg::TOTAL_MAX
                                                  : total_sum[ecs_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      total_r     <= total_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_energy_r <= energy;
      out_sens_r   <= ecs_pkg::SENS_W'(0) - sens_mag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {total_r, out_sens_r, out_energy_r};

  `ECS_ASSERT_NXT(a_accept_starts, in_acc, busy_r && (step_r == '0))
  `ECS_ASSERT_IMP(a_step_bound, busy_r, step_r <= ecs_pkg::STEP_LAST)
  `ECS_ASSERT_NXT(a_load_frees, out_load, !busy_r && out_valid_r)
  `ECS_ASSERT_IMP(a_zero_energy, out_valid_r && (out_energy_r == '0), out_sens_r == '0)
  `ECS_ASSERT_IMP(a_total_covers, out_valid_r, total_r >= ecs_pkg::TOTAL_W'(out_energy_r))

endmodule

@@ hw/rtl/ecs_lane.sv @@
// one row lane: dot product of a stiffness row with the displacements,
// then scaled by the lane's own displacement; uses ecs_pkg
module ecs_lane #(
  parameter int LANE = 0
) (
  input  logic                                clk,
  input  ecs_pkg::lane_ctrl_t                 ctrl,
  input  logic [ecs_pkg::COL_W-1:0]           col,
  input  ecs_pkg::stiff_t                     stiff [ecs_pkg::NUM_K],
  input  ecs_pkg::disp_t                      u_col,
  input  ecs_pkg::disp_t                      u_own,
  output ecs_pkg::lane_sum_t                  lane_sum
);

  logic signed [ecs_pkg::PROD_W-1:0] prod_r;
  logic signed [ecs_pkg::ROW_W-1:0]  acc_r;
  logic signed [ecs_pkg::PLO_W-1:0]  plo_r;
  logic signed [ecs_pkg::PHI_W-1:0]  phi_r;
  ecs_pkg::lane_sum_t                out_r;

  ecs_pkg::stiff_t                   k_sel;
  logic signed [ecs_pkg::PROD_W-1:0] prod_nxt;
  logic signed [ecs_pkg::PLO_W-1:0]  plo_nxt;
  logic signed [ecs_pkg::PHI_W-1:0]  phi_nxt;

  assign k_sel    = stiff[ecs_pkg::KIDX[LANE][col]];
  assign prod_nxt = k_sel * u_col;
  // row sum split so each finishing product stays near 32 x 32
  assign plo_nxt  = u_own * $signed({1'b0, acc_r[ecs_pkg::LO_W-1:0]});
  assign phi_nxt  = u_own * $signed(acc_r[ecs_pkg::ROW_W-1:ecs_pkg::LO_W]);

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.add) begin
      acc_r <= acc_r + ecs_pkg::ROW_W'(prod_r);
    end
    if (ctrl.fin_mul) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (ctrl.fin_add) begin
      out_r <= (ecs_pkg::LANE_W'(phi_r) <<< ecs_pkg::LO_W) + ecs_pkg::LANE_W'(plo_r);
    end
  end

  assign lane_sum = out_r;

endmodule

@@ hw/rtl/ecs_merge.sv @@
// merge stage: registered adder tree over the lanes, energy clamping and
// saturation, then the sensitivity magnitude; uses ecs_pkg
module ecs_merge (
  input  logic                            clk,
  input  ecs_pkg::merge_ctrl_t            ctrl,
  input  ecs_pkg::lane_sum_t              lane_sum [ecs_pkg::NUM_LANES],
  input  logic [ecs_pkg::DENS_W-1:0]      density,
  output logic [ecs_pkg::ENERGY_W-1:0]    energy,
  output logic [ecs_pkg::SENS_W-1:0]      sens_mag
);

  localparam int T1_W = ecs_pkg::LANE_W + 1;
  localparam int T2_W = ecs_pkg::LANE_W + 2;

  logic signed [T1_W-1:0]           t1_r [4];
  logic signed [T2_W-1:0]           t2_r [2];
  logic signed [ecs_pkg::SUM_W-1:0] t3_r;
  logic [ecs_pkg::ENERGY_W-1:0]     energy_r;
  logic [ecs_pkg::E3_W-1:0]         e3_r;
  logic [ecs_pkg::D2_W-1:0]         d2_r;
  logic [ecs_pkg::PP_W-1:0]         pl_r;
  logic [ecs_pkg::PP_W-1:0]         ph_r;
  logic [ecs_pkg::SENS_W-1:0]       mag_r;

  logic [ecs_pkg::ENERGY_W-1:0]     energy_nxt;
  logic [ecs_pkg::D2_W-1:0]         d2_nxt;
  logic [ecs_pkg::PP_W-1:0]         pl_nxt;
  logic [ecs_pkg::PP_W-1:0]         ph_nxt;
  logic [ecs_pkg::FULL_W-1:0]       full_c;
  logic [ecs_pkg::FULL_W-ecs_pkg::SENS_SH-1:0] mfull_c;

  // negative form means an indefinite matrix: clamp to zero
  always_comb begin
    priority if (t3_r[ecs_pkg::SUM_W-1]) begin
      energy_nxt = '0;
    end else if (|t3_r[ecs_pkg::SUM_W-2:ecs_pkg::ENERGY_W+ecs_pkg::FRAC_SH]) begin
      energy_nxt = ecs_pkg::ENERGY_MAX;
    end else begin
      energy_nxt = t3_r[ecs_pkg::ENERGY_W+ecs_pkg::FRAC_SH-1:ecs_pkg::FRAC_SH];
    end
  end

  assign d2_nxt  = density * density;
  assign pl_nxt  = e3_r[ecs_pkg::E3_HALF-1:0] * d2_r;
  assign ph_nxt  = e3_r[ecs_pkg::E3_W-1:ecs_pkg::E3_HALF] * d2_r;
  assign full_c  = (ecs_pkg::FULL_W'(ph_r) << ecs_pkg::E3_HALF) + ecs_pkg::FULL_W'(pl_r);
  assign mfull_c = full_c[ecs_pkg::FULL_W-1:ecs_pkg::SENS_SH];

  always_ff @(posedge clk) begin
    if (ctrl.tree1) begin
      for (int i = 0; i < 4; i++) begin
        t1_r[i] <= T1_W'(lane_sum[2*i]) + T1_W'(lane_sum[2*i+1]);
      end
    end
    if (ctrl.tree2) begin
      for (int i = 0; i < 2; i++) begin
        t2_r[i] <= T2_W'(t1_r[2*i]) + T2_W'(t1_r[2*i+1]);
      end
    end
    if (ctrl.tree3) begin
      t3_r <= ecs_pkg::SUM_W'(t2_r[0]) + ecs_pkg::SUM_W'(t2_r[1]);
    end
    if (ctrl.sat) begin
      energy_r <= energy_nxt;
    end
    if (ctrl.e3) begin
      e3_r <= (ecs_pkg::E3_W'(energy_r) << 1) + ecs_pkg::E3_W'(energy_r);
      d2_r <= d2_nxt;
    end
    if (ctrl.mul) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (ctrl.comb) begin
      if (mfull_c > (ecs_pkg::FULL_W-ecs_pkg::SENS_SH)'(ecs_pkg::SENS_MAG_MAX)) begin
        mag_r <= ecs_pkg::SENS_MAG_MAX;
      end else begin
        mag_r <= mfull_c[ecs_pkg::SENS_W-1:0];
      end
    end
  end

  assign energy   = energy_r;
  assign sens_mag = mag_r;

endmodule

@@ tb/tb_element_compliance_sensitivity.sv @@
// self-checking testbench for element_compliance_sensitivity
// depends on ecs_pkg and the block's rtl; predicts energy, sensitivity and running total
`timescale 1ns / 1ps

module tb_element_compliance_sensitivity;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int SAT_RUN      = 130;
  localparam logic [31:0] D_MAX = 32'h7fff_ffff;
  localparam logic [31:0] D_MIN = 32'h8000_0000;
  localparam logic [31:0] D_ONE = 32'h0001_0000;
  localparam logic [16:0] DENS_ONE = 17'h10000;
  localparam logic [16:0] DENS_TOP = 17'h1ffff;

  // stiffness word used at row, column
  localparam logic [2:0] KMAP [8][8] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2},
    '{3'd2, 3'd7, 3'd0, 3'd5, 3'd6, 3'd3, 3'd4, 3'd1},
    '{3'd3, 3'd6, 3'd5, 3'd0, 3'd7, 3'd2, 3'd1, 3'd4},
    '{3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6},
    '{3'd6, 3'd3, 3'd4, 3'd1, 3'd2, 3'd7, 3'd0, 3'd5},
    '{3'd7, 3'd2, 3'd1, 3'd4, 3'd3, 3'd6, 3'd5, 3'd0}
  };
  localparam logic [31:0] STIFF_DEFAULT [8] = '{
    32'd530971232, 32'd191739611, -32'sd324482419, -32'sd14749201,
    -32'sd265485616, -32'sd191739611, 32'd58996804, 32'd14749201
  };

  typedef struct packed {
    logic             restart;
    logic [16:0]      dens;
    logic [7:0][31:0] disp;
  } element_t;

  typedef struct packed {
    logic [62:0] total;
    logic [48:0] sens;
    logic [47:0] energy;
  } result_t;

  typedef struct packed {
    logic [ecs_pkg::CFG_IDX_W-1:0] idx;
    logic [ecs_pkg::K_W-1:0]       val;
  } cfg_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [279:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ecs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ecs_pkg::K_W-1:0] cfg_data = '0;

  element_t  element_queue[$];
  result_t   predicted_words[$];
  cfg_word_t cfg_plan[$];
  ecs_pkg::stiff_t stiff_cfg [8];
  logic [62:0] run_total;

  logic in_fire = 1'b0;
  int errors = 0;
  int in_count = 0;
  int out_count = 0;
  int quiet = 0;
  int hold_left = 0;
  int next_hold = 150;
  logic calm;

  element_compliance_sensitivity dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // no idling on either side for a stretch of the run
  assign calm = (in_count >= 750) && (in_count < 1000);

  function automatic result_t compute_element(input element_t e);
    logic signed [127:0] acc;
    logic signed [127:0] term;
    logic [127:0] scaled;
    logic [83:0] sprod;
    logic [51:0] shifted;
    logic [48:0] mag;
    logic [63:0] sum;
    result_t w;
    acc = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        term = $signed(e.disp[r]) * $signed(e.disp[c]) * stiff_cfg[KMAP[r][c]];
        acc = acc + term;
      end
    end
    if (acc < 0) begin
      w.energy = '0;
    end else begin
      scaled = acc >>> 30;
      if (scaled > 128'hffff_ffff_ffff) w.energy = '1;
      else w.energy = scaled[47:0];
    end
    sprod = 84'(w.energy) * 84'd3 * 84'(e.dens) * 84'(e.dens);
    shifted = sprod[83:32];
    if (shifted > 52'h1_0000_0000_0000) mag = 49'h1_0000_0000_0000;
    else mag = shifted[48:0];
    w.sens = 49'd0 - mag;
    if (e.restart) run_total = '0;
    sum = 64'(run_total) + 64'(w.energy);
    if (sum > 64'h7fff_ffff_ffff_ffff) run_total = '1;
    else run_total = sum[62:0];
    w.total = run_total;
    return w;
  endfunction

  function automatic logic [31:0] rand_disp();
    logic signed [31:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 24);
  endfunction

  function automatic element_t rand_element();
    element_t e;
    for (int i = 0; i < 8; i++) e.disp[i] = rand_disp();
    if ($urandom_range(0, 3) == 0) e.dens = 17'($urandom);
    else e.dens = 17'($urandom_range(0, 65536));
    e.restart = ($urandom_range(0, 15) == 0);
    return e;
  endfunction

  function automatic element_t fill_element(input logic [31:0] even, input logic [31:0] odd,
                                            input logic [16:0] dens, input logic restart);
    element_t e;
    for (int i = 0; i < 8; i++) e.disp[i] = i[0] ? odd : even;
    e.dens = dens;
    e.restart = restart;
    return e;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) element_queue.push_back(rand_element());
  endtask

  task automatic write_stiffness();
    cfg_word_t w;
    while (cfg_plan.size() > 0) begin
      w = cfg_plan.pop_front();
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.val;
      do @(posedge clk); while (!cfg_ready);
      if (w.idx < ecs_pkg::NUM_K) stiff_cfg[w.idx] = w.val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_all(input logic [31:0] val);
    for (int i = 0; i < ecs_pkg::NUM_K; i++) begin
      cfg_plan.push_back('{ecs_pkg::CFG_IDX_W'(i), val});
    end
  endtask

  task automatic wait_idle();
    while (element_queue.size() != 0 || in_tvalid || predicted_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: one word per handshake, random gaps between words
  always @(negedge clk) begin
    element_t e;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (element_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        e = element_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {7'd0, e.dens, e.disp};
        in_tuser <= e.restart;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus two long hold-offs to back the block up
  always @(negedge clk) begin
    if (hold_left == 0 && out_count == next_hold) begin
      hold_left = HOLD_CYCLES;
      next_hold = (next_hold == 150) ? 700 : -1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    element_t e;
    result_t got;
    result_t want;
    logic out_fire;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      e = {in_tuser[0], in_tdata[272:256], in_tdata[255:0]};
      predicted_words.push_back(compute_element(e));
      in_count++;
    end
    if (out_fire) begin
      got = out_tdata;
      out_count++;
      if (predicted_words.size() == 0) begin
        errors++;
        $display("%0t unexpected result word %h", $time, out_tdata);
      end else begin
        want = predicted_words.pop_front();
        if (got.energy !== want.energy) begin
          errors++;
          $display("%0t energy: expected %h actual %h", $time, want.energy, got.energy);
        end
        if (got.sens !== want.sens) begin
          errors++;
          $display("%0t sensitivity: expected %h actual %h", $time, want.sens, got.sens);
        end
        if (got.total !== want.total) begin
          errors++;
          $display("%0t total_cost: expected %h actual %h", $time, want.total, got.total);
        end
      end
    end
    if (in_fire || out_fire || (cfg_valid && cfg_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    element_t e;
    for (int i = 0; i < ecs_pkg::NUM_K; i++) stiff_cfg[i] = STIFF_DEFAULT[i];
    run_total = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default stiffness: corners of the displacement and density ranges
    element_queue.push_back(fill_element(32'd0, 32'd0, 17'd0, 1'b1));
    element_queue.push_back(fill_element(D_MAX, D_MAX, DENS_ONE, 1'b0));
    element_queue.push_back(fill_element(D_MIN, D_MIN, DENS_ONE, 1'b0));
    element_queue.push_back(fill_element(D_MAX, D_MIN, DENS_ONE, 1'b0));
    element_queue.push_back(fill_element(D_MIN, D_MAX, DENS_TOP, 1'b0));
    element_queue.push_back(fill_element(32'hffff_ffff, 32'hffff_ffff, DENS_ONE, 1'b1));
    element_queue.push_back(fill_element(D_ONE, 32'd0, 17'd32768, 1'b0));
    e = fill_element(32'd0, 32'd0, 17'd1, 1'b0);
    e.disp[7] = 32'hffff_0000;
    element_queue.push_back(e);
    e = rand_element();
    e.dens = DENS_TOP;
    element_queue.push_back(e);
    element_queue.push_back(fill_element(D_ONE, 32'hffff_0000, DENS_ONE, 1'b1));
    wait_idle();

    // all words at the positive extreme, out of range indexes dropped
    plan_all(D_MAX);
    cfg_plan.push_back('{ecs_pkg::CFG_IDX_W'(8), 32'h0});
    cfg_plan.push_back('{'1, 32'h0});
    write_stiffness();
    element_queue.push_back(fill_element(D_MAX, D_MAX, DENS_TOP, 1'b1));
    element_queue.push_back(fill_element(D_MIN, D_MIN, 17'd0, 1'b0));
    // saturated energy every word
    for (int i = 0; i < SAT_RUN; i++) begin
      for (int j = 0; j < 8; j++) e.disp[j] = {2'b01, 30'($urandom)};
      e.dens = 17'($urandom);
      e.restart = (i == 0);
      element_queue.push_back(e);
    end
    wait_idle();

    // negative extreme: indefinite matrix, energy clamps to zero
    plan_all(D_MIN);
    write_stiffness();
    element_queue.push_back(fill_element(D_MAX, D_MAX, DENS_ONE, 1'b1));
    element_queue.push_back(fill_element(D_ONE, 32'd0, DENS_ONE, 1'b0));
    element_queue.push_back(fill_element(D_MAX, D_MIN, DENS_TOP, 1'b0));
    queue_random(150);
    wait_idle();

    plan_all(32'd0);
    write_stiffness();
    element_queue.push_back(fill_element(D_MAX, D_MIN, DENS_TOP, 1'b0));
    queue_random(50);
    wait_idle();

    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < ecs_pkg::NUM_K; i++) begin
        cfg_plan.push_back('{ecs_pkg::CFG_IDX_W'(i), 32'($urandom) >>> $urandom_range(0, 4)});
      end
      cfg_plan.push_back('{ecs_pkg::CFG_IDX_W'($urandom_range(8, 255)), 32'($urandom)});
      write_stiffness();
      queue_random(100);
      wait_idle();
    end

    for (int i = 0; i < ecs_pkg::NUM_K; i++) begin
      cfg_plan.push_back('{ecs_pkg::CFG_IDX_W'(i), STIFF_DEFAULT[i]});
    end
    write_stiffness();
    queue_random(400);
    wait_idle();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
